### rtl/core/rksd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rksd_pkg
// Shared types and constants of the rolling key stream descrambler.
// ----------------------------------------------------------------------------
package rksd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned KeyIdxW   = 3;
  localparam int unsigned CtrShift  = 6;

  localparam logic [KeyIdxW-1:0] KeyIdxFirst = 3'd0;
  localparam logic [KeyIdxW-1:0] KeyIdxLast  = 3'd7;

  typedef struct packed {
    logic             start_of_block;
    logic [ByteW-1:0] cipher_byte;
  } rksd_word_t;

endpackage

### rtl/core/rksd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rksd_in_stage
// Input register: captures one word per cycle while empty or advancing, and holds it until it advances.
// ----------------------------------------------------------------------------
module rksd_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  rksd_pkg::rksd_word_t word_i,
  input  logic               advance_i,
  output logic               valid_o,
  output rksd_pkg::rksd_word_t word_o
);
  import rksd_pkg::*;

  logic       valid_q;
  rksd_word_t word_q;

  assign s_axis_tready = !valid_q || advance_i;
  assign valid_o       = valid_q;
  assign word_o        = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      word_q <= word_i;
    end
  end

endmodule

### rtl/core/rksd_keystream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rksd_keystream
// Running key, byte counter and key index; descrambles the held word.
// ----------------------------------------------------------------------------
module rksd_keystream #(
  parameter int unsigned CounterWidth = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  rksd_pkg::rksd_word_t        word_i,
  input  logic [rksd_pkg::KeyW-1:0]   key_i,
  output logic [rksd_pkg::ByteW-1:0]  plain_byte_o,
  output logic [rksd_pkg::KeyIdxW-1:0] key_idx_o
);
  import rksd_pkg::*;

  logic [ByteW-1:0]        run_key_q, run_key_d;
  logic [CounterWidth-1:0] ctr_q, ctr_d, cur_ctr;
  logic [KeyIdxW-1:0]      idx_q, idx_d, cur_idx, nxt_idx;
  logic                    restart;
  logic [ByteW-1:0]        cur_key, rot;

  always_comb begin
    restart      = word_i.start_of_block || (ctr_q == '0);
    cur_key      = restart ? key_i[ByteW-1:0] : run_key_q;
    cur_idx      = restart ? KeyIdxFirst : idx_q;
    cur_ctr      = word_i.start_of_block ? '0 : ctr_q;
    plain_byte_o = word_i.cipher_byte ^ cur_key;
    nxt_idx      = cur_idx + KeyIdxW'(1);
    rot          = {cur_key[ByteW-2:0], cur_key[ByteW-1]};
    ctr_d        = cur_ctr + CounterWidth'(1);
    run_key_d    = key_i[{nxt_idx, 3'b000} +: ByteW] + rot + ctr_d[CtrShift +: ByteW];
    idx_d        = (nxt_idx == KeyIdxLast) ? KeyIdxFirst : nxt_idx;
  end

  assign key_idx_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_key_q <= '0;
      ctr_q     <= '0;
      idx_q     <= KeyIdxFirst;
    end else if (advance_i) begin
      run_key_q <= run_key_d;
      ctr_q     <= ctr_d;
      idx_q     <= idx_d;
    end
  end

endmodule

### rtl/core/rolling_key_stream_descrambler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_key_stream_descrambler_top
// Descrambles a byte stream with an eight-byte rolling key.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata              tuser
// s_axis    in         [7:0] cipher_byte  [0] start_of_block
// m_axis    out        [7:0] plain_byte   -
// cfg       in         cfg_wr_data_i [63:0] cipher_key, written when cfg_wr_en_i
//
// One word per cycle while the output is not stalled; the input and result registers lie between input and output.
// The key update is one rotate and two adds between the two registers.
// Reset clears the key, counter, key index and all valid flags.
// A stalled output holds its word; the input keeps taking words while a slot is free.
// ----------------------------------------------------------------------------
module rolling_key_stream_descrambler_top #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] cipher_byte
  input  logic [0:0]  s_axis_tuser,  // [0] start_of_block
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] plain_byte
  input  logic        cfg_wr_en_i,
  input  logic [63:0] cfg_wr_data_i
);
  import rksd_pkg::*;

  logic [KeyW-1:0]    key_q;
  rksd_word_t         in_word, held_word;
  logic               held_valid, advance;
  logic [ByteW-1:0]   plain_byte;
  logic [KeyIdxW-1:0] key_idx;
  logic               out_valid_q;
  logic [ByteW-1:0]   out_data_q;

  assign in_word.cipher_byte    = s_axis_tdata;
  assign in_word.start_of_block = s_axis_tuser[0];
  assign advance                = held_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_wr_en_i) begin
      key_q <= cfg_wr_data_i;
    end
  end

  rksd_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .word_i        (in_word),
    .advance_i     (advance),
    .valid_o       (held_valid),
    .word_o        (held_word)
  );

  rksd_keystream #(
    .CounterWidth (COUNTER_WIDTH)
  ) u_keystream (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .word_i       (held_word),
    .key_i        (key_q),
    .plain_byte_o (plain_byte),
    .key_idx_o    (key_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= plain_byte;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_idx != KeyIdxLast)
    else $error("key index reached the last key byte");

  a_sob_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && held_word.start_of_block |=> key_idx == (KeyIdxFirst + KeyIdxW'(1)))
    else $error("start of block did not restart the key index");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("output word appeared without an advance");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid && !advance |=> $stable(held_word) && held_valid)
    else $error("held input word changed while waiting");
`endif

endmodule

### test/rolling_key_stream_descrambler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_key_stream_descrambler_top_tb
// Self-checking bench for the rolling key stream descrambler. A clocked
// driver plays queued cipher words into the slave side and predicts each
// plain byte as the word is taken; a clocked monitor compares every word on
// the master side with the oldest prediction. The key is rewritten between
// drained phases: extremes, random keys, key changes inside an open block, short and
// long blocks, random idling on both sides, and one long block that carries
// the byte counter into its upper bits.
// ----------------------------------------------------------------------------
module rolling_key_stream_descrambler_top_tb;
  import rksd_pkg::*;

  localparam int unsigned CtrW      = 14;
  localparam int unsigned LongRun   = 200;
  localparam int unsigned DrainMax  = 2000;
  localparam int unsigned IdleMax   = 3;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata  = '0;
  logic [0:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ByteW-1:0]   m_axis_tdata;
  logic               cfg_wr_en_i   = 1'b0;
  logic [KeyW-1:0]    cfg_wr_data_i = '0;

  rksd_word_t         cipher_words_q[$];
  logic [ByteW-1:0]   plain_bytes_due[$];
  rksd_word_t         next_word;
  logic [ByteW-1:0]   plain_due;

  logic [KeyW-1:0]    key_reg;
  logic [ByteW-1:0]   roll_key;
  logic [CtrW-1:0]    byte_count;
  logic [KeyIdxW-1:0] key_sel;

  bit                 send_idle;
  bit                 recv_idle;
  int unsigned        send_gap;
  int unsigned        recv_gap;
  int unsigned        draw;
  int unsigned        fail_count;

  rolling_key_stream_descrambler_top #(
    .COUNTER_WIDTH(CtrW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [ByteW-1:0] descramble_byte(logic [ByteW-1:0] cb, logic sob);
    logic [ByteW-1:0]   plain;
    logic [ByteW-1:0]   rot;
    logic [KeyIdxW-1:0] nxt;
    if (sob) begin
      byte_count = '0;
      key_sel    = KeyIdxFirst;
    end
    if (byte_count == '0) begin
      roll_key = key_reg[ByteW-1:0];
      key_sel  = KeyIdxFirst;
    end
    plain      = cb ^ roll_key;
    nxt        = key_sel + 1'b1;
    rot        = {roll_key[ByteW-2:0], roll_key[ByteW-1]};
    byte_count = byte_count + 1'b1;
    roll_key   = key_reg[nxt*ByteW +: ByteW] + rot + byte_count[CtrShift +: ByteW];
    key_sel    = (nxt >= KeyIdxLast) ? KeyIdxFirst : nxt;
    return plain;
  endfunction

  // Driver: predict on each taken word, then present the next after its gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        plain_bytes_due.push_back(descramble_byte(s_axis_tdata, s_axis_tuser[0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (cipher_words_q.size() != 0) begin
          next_word     = cipher_words_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_word.cipher_byte;
          s_axis_tuser  <= next_word.start_of_block;
          send_gap      <= send_idle ? $urandom_range(0, IdleMax) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken word, then stall for a randomly drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (plain_bytes_due.size() == 0) begin
          $error("plain_byte: expected none, actual 0x%02h", m_axis_tdata);
          fail_count++;
        end else begin
          plain_due = plain_bytes_due.pop_front();
          if (m_axis_tdata !== plain_due) begin
            $error("plain_byte: expected 0x%02h, actual 0x%02h", plain_due, m_axis_tdata);
            fail_count++;
          end
        end
        draw          = recv_idle ? $urandom_range(0, IdleMax) : 0;
        m_axis_tready <= (draw == 0);
        recv_gap      <= draw;
      end else if (recv_gap != 0) begin
        m_axis_tready <= (recv_gap == 1);
        recv_gap      <= recv_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    int unsigned n;
    n = 0;
    while ((cipher_words_q.size() != 0 || s_axis_tvalid || plain_bytes_due.size() != 0)
           && n < DrainMax) begin
      @(negedge clk_i);
      n++;
    end
    if (plain_bytes_due.size() != 0 || cipher_words_q.size() != 0 || s_axis_tvalid) begin
      $error("plain_byte: %0d words still due", plain_bytes_due.size());
      fail_count++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_key(logic [KeyW-1:0] value);
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    key_reg       = value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic push_word(logic [ByteW-1:0] cb, logic sob);
    rksd_word_t w;
    w.cipher_byte    = cb;
    w.start_of_block = sob;
    cipher_words_q.push_back(w);
  endtask

  task automatic push_blocks(int unsigned count, bit open_start);
    int unsigned left;
    logic        sob;
    left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(1, 48);
        sob  = !(i == 0 && open_start);
      end else begin
        sob  = ($urandom_range(0, 15) == 0);
      end
      left--;
      push_word(8'($urandom_range(0, 255)), sob);
    end
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int unsigned random_left;
    int unsigned chunk;
    fail_count = 0;
    key_reg    = '0;
    roll_key   = '0;
    byte_count = '0;
    key_sel    = KeyIdxFirst;
    send_idle  = 1'b1;
    recv_idle  = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset key, first word without start of block.
    push_word(8'h00, 1'b0);
    push_word(8'hff, 1'b0);
    push_word(8'h5a, 1'b1);
    push_word(8'ha5, 1'b0);
    wait_drained();

    write_key('1);
    push_word(8'h00, 1'b1);
    push_word(8'hff, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'hff, 1'b1);
    push_word(8'h80, 1'b1);
    push_word(8'h01, 1'b0);
    push_word(8'h7f, 1'b0);
    wait_drained();

    // Change the key inside an open block and run the index through a full cycle.
    write_key(64'h0123_4567_89ab_cdef);
    for (int unsigned i = 0; i < 10; i++) push_word(8'(i * 8'h1d), 1'b0);
    wait_drained();

    random_left = 200;
    while (random_left != 0) begin
      chunk = $urandom_range(20, 80);
      if (chunk > random_left) chunk = random_left;
      random_left -= chunk;
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      write_key(pick_key());
      push_blocks(chunk, 1'($urandom_range(0, 1)));
      wait_drained();
    end

    // One long block that carries the byte counter into its upper bits.
    send_idle = 1'b0;
    recv_idle = 1'b0;
    write_key({$urandom, $urandom});
    push_word(8'($urandom_range(0, 255)), 1'b1);
    for (int unsigned i = 1; i < LongRun; i++) push_word(8'($urandom_range(0, 255)), 1'b0);
    wait_drained();

    send_idle = 1'b1;
    recv_idle = 1'b1;
    push_blocks(20, 1'b1);
    wait_drained();
    repeat (8) @(negedge clk_i);

    if (fail_count == 0 && plain_bytes_due.size() == 0) begin
      $display("** rolling_key_stream_descrambler_top: PASSED **");
    end else begin
      $display("** rolling_key_stream_descrambler_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #1_500_000;
    $display("** rolling_key_stream_descrambler_top: FAILED **");
    $finish;
  end

endmodule

### rolling_key_stream_descrambler_top.f
rtl/core/rksd_pkg.sv
rtl/core/rksd_in_stage.sv
rtl/core/rksd_keystream.sv
rtl/core/rolling_key_stream_descrambler_top.sv
test/rolling_key_stream_descrambler_top_tb.sv
